### rtl/ncet_pkg.sv
// ----------------------------------------------------------------------------
// Neighbor-count endpoint table package
// Shared types and constants for the neighbor-count endpoint table.
// ----------------------------------------------------------------------------
package ncet_pkg;

  localparam int unsigned CfgIdxBits = 2;
  localparam int unsigned CfgDataBits = 64;
  localparam int unsigned CountBits = 16;
  localparam logic [CountBits-1:0] CountMax = '1;

  typedef enum logic [1:0] {
    ActAdd   = 2'd0,
    ActQuery = 2'd1,
    ActClear = 2'd2,
    ActNone  = 2'd3
  } action_e;

  typedef enum logic [CfgIdxBits-1:0] {
    RegOffsLo  = 2'd0,
    RegOffsHi  = 2'd1,
    RegOffsCnt = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
  } in_item_t;

  typedef struct packed {
    logic [CountBits-1:0] neighbor_count;
    logic                 one_neighbor;
    logic                 status;
  } out_item_t;

  typedef enum logic [3:0] {
    StIdle,
    StKey,
    StRead,
    StWait,
    StCmp,
    StWrite,
    StNext,
    StDone
  } state_e;

endpackage

### rtl/ncet_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or read per cycle with registered read data.
// ----------------------------------------------------------------------------
module ncet_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

### rtl/neighbor_count_endpoint_table_top.sv
// ----------------------------------------------------------------------------
// Neighbor-count endpoint table
// Counts how often each coordinate is reached from added points by the
// configured direction offsets, and answers count queries.
// ----------------------------------------------------------------------------
//  Channel  Signals                        Transfer when
//  in       in_valid_i, in_stall_o, in_i   valid high, stall low
//  out      out_valid_o, out_stall_i, out_o valid high, stall low
//  cfg      cfg_valid_i, cfg_ready_o       valid and ready high
//
// The table is searched linearly over the used entries through one memory
// port, each entry examined passing through the read, wait and compare
// states; an add searches once per offset in use and a query searches once.
// A clear resets the fill count in one step and needs no sweep.
// The input stalls while an item is at work. A finished result waits in the
// output register, and the next item may start but does not finish before it.
// ----------------------------------------------------------------------------
module neighbor_count_endpoint_table_top
  import ncet_pkg::*;
#(
  parameter int unsigned TableEntries = 4096,
  parameter int unsigned CoordBits = 16,
  parameter int unsigned MaxOffsets = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  in_item_t               in_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output out_item_t              out_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxBits-1:0]  cfg_index_i,
  input  logic [CfgDataBits-1:0] cfg_data_i
);

  localparam int unsigned AddrBits = $clog2(TableEntries);
  localparam int unsigned UsedBits = $clog2(TableEntries + 1);
  localparam int unsigned KeyBits = 2 * CoordBits;

  logic [63:0] offs_lo_q, offs_hi_q;
  logic [3:0]  offs_cnt_q;

  state_e                state_q, state_d;
  logic [1:0]            act_q, act_d;
  logic [CoordBits-1:0]  px_q, px_d, py_q, py_d;
  logic [3:0]            dir_q, dir_d, ndir;
  logic [KeyBits-1:0]    key_q, key_d;
  logic [UsedBits-1:0]   used_q, used_d, idx_q, idx_d;
  logic                  drop_q, drop_d;
  logic [CountBits-1:0]  cnt_q, cnt_d;
  logic                  ovalid_q, ovalid_d;
  out_item_t             out_q, out_d;

  logic                  we;
  logic [AddrBits-1:0]   addr;
  logic [KeyBits-1:0]    wkey, rkey;
  logic [CountBits-1:0]  wcnt, rcnt;
  logic [15:0]           pair;
  logic [CoordBits-1:0]  dx, dy;

  ncet_ram #(.Width(KeyBits), .Depth(TableEntries)) u_keys (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wkey), .rdata_o(rkey));
  ncet_ram #(.Width(CountBits), .Depth(TableEntries)) u_cnts (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wcnt), .rdata_o(rcnt));

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = ovalid_q;
  assign out_o       = out_q;
  assign ndir = (offs_cnt_q > 4'(MaxOffsets)) ? 4'(MaxOffsets) : offs_cnt_q;

  always_comb begin
    pair = dir_q[2] ? offs_hi_q[16*dir_q[1:0] +: 16] : offs_lo_q[16*dir_q[1:0] +: 16];
    dx = CoordBits'(signed'(pair[7:0]));
    dy = CoordBits'(signed'(pair[15:8]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offs_lo_q <= '0;
      offs_hi_q <= '0;
      offs_cnt_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegOffsLo:  offs_lo_q <= cfg_data_i;
        RegOffsHi:  offs_hi_q <= cfg_data_i;
        RegOffsCnt: offs_cnt_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      used_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      used_q   <= used_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q  <= act_d;
    px_q   <= px_d;
    py_q   <= py_d;
    dir_q  <= dir_d;
    key_q  <= key_d;
    idx_q  <= idx_d;
    drop_q <= drop_d;
    cnt_q  <= cnt_d;
    out_q  <= out_d;
  end

  always_comb begin
    state_d  = state_q;
    act_d    = act_q;
    px_d     = px_q;
    py_d     = py_q;
    dir_d    = dir_q;
    key_d    = key_q;
    idx_d    = idx_q;
    drop_d   = drop_q;
    cnt_d    = cnt_q;
    used_d   = used_q;
    ovalid_d = ovalid_q && out_stall_i;
    out_d    = out_q;
    we       = 1'b0;
    addr     = idx_q[AddrBits-1:0];
    wkey     = key_q;
    wcnt     = cnt_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i && !in_stall_o) begin
          act_d  = in_i.action;
          px_d   = CoordBits'(signed'(in_i.point_x));
          py_d   = CoordBits'(signed'(in_i.point_y));
          dir_d  = '0;
          drop_d = 1'b0;
          cnt_d  = '0;
          state_d = StKey;
        end
      end
      StKey: begin
        idx_d = '0;
        unique case (act_q)
          ActAdd: begin
            if (dir_q >= ndir) state_d = StDone;
            else begin
              key_d = {py_q + dy, px_q + dx};
              state_d = StRead;
            end
          end
          ActQuery: begin
            key_d = {py_q, px_q};
            state_d = StRead;
          end
          ActClear: begin
            used_d = '0;
            state_d = StDone;
          end
          default: state_d = StDone;
        endcase
      end
      StRead: begin
        if (idx_q >= used_q) begin
          if (act_q == ActQuery) begin
            cnt_d = '0;
            state_d = StDone;
          end else if (used_q >= UsedBits'(TableEntries)) begin
            drop_d = 1'b1;
            state_d = StNext;
          end else begin
            cnt_d = '0;
            state_d = StWrite;
          end
        end else begin
          state_d = StWait;
        end
      end
      StWait: state_d = StCmp;
      StCmp: begin
        if (rkey == key_q) begin
          cnt_d = rcnt;
          state_d = (act_q == ActQuery) ? StDone : StWrite;
        end else begin
          idx_d = idx_q + 1'b1;
          state_d = StRead;
        end
      end
      StWrite: begin
        we = 1'b1;
        wcnt = (cnt_q == CountMax) ? cnt_q : cnt_q + 1'b1;
        if (idx_q >= used_q) used_d = used_q + 1'b1;
        state_d = StNext;
      end
      StNext: begin
        dir_d = dir_q + 1'b1;
        state_d = StKey;
      end
      StDone: begin
        if (!ovalid_q) begin
          ovalid_d = 1'b1;
          out_d.neighbor_count = (act_q == ActQuery) ? cnt_q : '0;
          out_d.one_neighbor = (act_q == ActQuery) && (cnt_q == CountBits'(1));
          out_d.status = (act_q == ActAdd) && drop_q;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

endmodule

### sim/tb_neighbor_count_endpoint_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Neighbor-count endpoint table testbench
// Drives add, query, clear and no-op items through the table under several offset
// settings and random handshake idling, predicts every result with a
// behavioral copy of the keyed table, and compares each transfer field by
// field.
// ----------------------------------------------------------------------------
module tb_neighbor_count_endpoint_table_top;
  import ncet_pkg::*;

  localparam int unsigned NumEntries = 4096;
  localparam int unsigned NumDirs = 8;
  localparam int unsigned WatchdogLimit = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxBits-1:0] cfg_index = '0;
  logic [CfgDataBits-1:0] cfg_data = '0;

  neighbor_count_endpoint_table_top uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_i(in_item),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_o(out_item),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always #1 clk = ~clk;

  logic [63:0] dirs_lo, dirs_hi;
  logic [3:0] dir_total;
  logic [31:0] key_store[NumEntries];
  logic [15:0] count_store[NumEntries];
  int unsigned fill;

  in_item_t pending_items[$];
  out_item_t expected_results[$];
  int unsigned sender_idle_pct, receiver_idle_pct;
  int unsigned mismatches;
  int unsigned quiet_cycles;

  function automatic logic [31:0] point_key(logic [15:0] x, logic [15:0] y);
    return {y, x};
  endfunction

  function automatic int find_slot(logic [31:0] key);
    for (int unsigned i = 0; i < fill; i++) begin
      if (key_store[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic out_item_t table_step(in_item_t item);
    out_item_t res;
    int slot;
    int unsigned n;
    logic [15:0] pair;
    logic [15:0] nx, ny;
    logic [31:0] key;
    res = '0;
    case (action_e'(item.action))
      ActAdd: begin
        n = (dir_total > NumDirs) ? NumDirs : dir_total;
        for (int unsigned k = 0; k < n; k++) begin
          pair = (k < 4) ? dirs_lo[16*(k%4) +: 16] : dirs_hi[16*(k%4) +: 16];
          nx = item.point_x + {{8{pair[7]}}, pair[7:0]};
          ny = item.point_y + {{8{pair[15]}}, pair[15:8]};
          key = point_key(nx, ny);
          slot = find_slot(key);
          if (slot < 0) begin
            if (fill >= NumEntries) begin
              res.status = 1'b1;
              continue;
            end
            slot = fill;
            key_store[slot] = key;
            count_store[slot] = '0;
            fill++;
          end
          if (count_store[slot] != CountMax) count_store[slot]++;
        end
      end
      ActQuery: begin
        slot = find_slot(point_key(item.point_x, item.point_y));
        if (slot >= 0) res.neighbor_count = count_store[slot];
        res.one_neighbor = (res.neighbor_count == 16'd1);
      end
      ActClear: fill = 0;
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_results = {expected_results, table_step(in_item)};
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_item <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < receiver_idle_pct);
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_e'(cfg_index))
          RegOffsLo: dirs_lo = cfg_data;
          RegOffsHi: dirs_hi = cfg_data;
          RegOffsCnt: dir_total = cfg_data[3:0];
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transfer: %p", out_item);
      end else begin
        out_item_t want;
        want = expected_results.pop_front();
        if (want.neighbor_count !== out_item.neighbor_count
            || want.one_neighbor !== out_item.one_neighbor
            || want.status !== out_item.status) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Result mismatch: expected %p, got %p", want, out_item);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
        || !rst_n) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("tb_neighbor_count_endpoint_table_top NOT OK");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [63:0] value);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
  endtask

  function automatic in_item_t make_item(action_e act, logic [15:0] x, logic [15:0] y);
    in_item_t item;
    item.action = act;
    item.point_x = x;
    item.point_y = y;
    return item;
  endfunction

  function automatic void queue_item(in_item_t item);
    pending_items = {pending_items, item};
  endfunction

  task automatic set_offsets(logic [63:0] lo, logic [63:0] hi, logic [3:0] total);
    write_reg(RegOffsLo, lo);
    write_reg(RegOffsHi, hi);
    write_reg(RegOffsCnt, 64'(total));
  endtask

  task automatic random_phase(int unsigned items, int unsigned span);
    logic [15:0] bx, by, x, y;
    int unsigned pick;
    bx = 16'($urandom);
    by = 16'($urandom);
    for (int unsigned i = 0; i < items; i++) begin
      x = 16'(bx + $urandom_range(span) - span / 2);
      y = 16'(by + $urandom_range(span) - span / 2);
      pick = $urandom_range(99);
      if (pick < 3) queue_item(make_item(ActClear, 16'($urandom), 16'($urandom)));
      else if (pick < 5) queue_item(make_item(ActNone, 16'($urandom), 16'($urandom)));
      else if (pick < 8) queue_item(make_item(ActQuery, 16'($urandom), 16'($urandom)));
      else if (pick < 50) queue_item(make_item(ActAdd, x, y));
      else queue_item(make_item(ActQuery, x, y));
    end
    wait_drained();
  endtask

  initial begin
    fill = 0;
    dirs_lo = '0;
    dirs_hi = '0;
    dir_total = '0;
    mismatches = 0;
    sender_idle_pct = 6;
    receiver_idle_pct = 48;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    queue_item(make_item(ActAdd, 16'd5, 16'd5));
    queue_item(make_item(ActQuery, 16'd5, 16'd5));
    wait_drained();

    set_offsets({8'h00, 8'h01, 8'h01, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00},
                {8'h7F, 8'h80, 8'h80, 8'h7F, 8'h00, 8'h01, 8'h00, 8'h01}, 4'd8);
    queue_item(make_item(ActAdd, 16'h7FFF, 16'h7FFF));
    queue_item(make_item(ActAdd, 16'h8000, 16'h8000));
    queue_item(make_item(ActAdd, 16'hFFFF, 16'h0000));
    queue_item(make_item(ActQuery, 16'h8000, 16'h7FFF));
    queue_item(make_item(ActQuery, 16'h0000, 16'h8000));
    queue_item(make_item(ActQuery, 16'h0000, 16'h0001));
    queue_item(make_item(ActQuery, 16'h8000, 16'h8001));
    queue_item(make_item(ActQuery, 16'h007E, 16'h7F7F));
    queue_item(make_item(ActQuery, 16'h1234, 16'h4321));
    queue_item(make_item(ActNone, 16'hFFFF, 16'hFFFF));
    queue_item(make_item(ActClear, 16'h0, 16'h0));
    queue_item(make_item(ActQuery, 16'h8000, 16'h7FFF));
    wait_drained();

    // Offset count above the direction limit, with repeated offsets.
    set_offsets({4{16'h0101}}, {4{16'h0101}}, 4'd15);
    queue_item(make_item(ActAdd, 16'd0, 16'd0));
    queue_item(make_item(ActAdd, 16'd0, 16'd0));
    queue_item(make_item(ActQuery, 16'd1, 16'd1));
    queue_item(make_item(ActClear, 16'd0, 16'd0));
    wait_drained();

    set_offsets({16'h0001, 16'hFF00, 16'h0100, 16'h00FF}, 64'($urandom), 4'd4);
    random_phase(250, 16);

    sender_idle_pct = 48;
    receiver_idle_pct = 6;
    set_offsets({$urandom, $urandom}, {$urandom, $urandom}, 4'd1);
    random_phase(200, 6);
    set_offsets({$urandom, $urandom} & 64'h0303_0303_0303_0303,
                {$urandom, $urandom} & 64'h0303_0303_0303_0303, 4'd8);
    random_phase(150, 10);

    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    set_offsets({$urandom, $urandom}, {$urandom, $urandom}, 4'd0);
    random_phase(60, 4);
    set_offsets(64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000, 4'd2);
    random_phase(250, 20);

    if (mismatches == 0) begin
      $display("tb_neighbor_count_endpoint_table_top OK");
    end else begin
      $display("tb_neighbor_count_endpoint_table_top NOT OK");
    end
    $finish;
  end
endmodule
